### rtl/core/b64le_pkg.sv
// Shared types, character constants and the symbol function of the Base64 line-wrapping encoder.
`default_nettype none

package b64le_pkg;

   localparam logic [7:0] CHAR_PAD = 8'h3D;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;

   localparam logic [7:0]  GROUPS_RESET  = 8'd19;
   localparam logic [10:0] LINE_STEP     = 11'd4;
   localparam logic [2:0]  LAST_PLAIN    = 3'd3;
   localparam logic [2:0]  LAST_WRAPPED  = 3'd5;
   localparam logic [2:0]  IDX_CR        = 3'd4;

   // One group of four output characters, as the back end needs it.
   typedef struct packed {
      logic [3:0][5:0] sixes;
      logic [1:0]      pad;
      logic            wrap;
   } desc_type;

   function automatic logic [7:0] b64_symbol(input logic [5:0] six);
      logic [7:0] v8;
      logic [7:0] r;
      v8 = {2'b00, six};
      if (six < 6'd26) begin
         r = 8'h41 + v8;
      end else if (six < 6'd52) begin
         r = 8'h61 + v8 - 8'd26;
      end else if (six < 6'd62) begin
         r = 8'h30 + v8 - 8'd52;
      end else if (six == 6'd62) begin
         r = 8'h2B;
      end else begin
         r = 8'h2F;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/b64le_front.sv
// Front end: gathers bytes into groups, tracks the line length and issues group descriptors.
`default_nettype none

module b64le_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [7:0]         csr_write_data,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_final_byte,
   input  wire logic               q_full,
   output logic                    q_push,
   output b64le_pkg::desc_type     q_desc
);
   import b64le_pkg::*;

   logic [7:0]  cfg_ff;
   logic [15:0] pending_ff, pending_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [10:0] line_ff, line_in;

   logic        accept;
   logic        two_pending;
   logic        emit;
   logic [7:0]  b0, b1, b2;
   logic [1:0]  pad;
   logic [10:0] line_sum;
   logic [10:0] line_limit;
   logic        wrap;

   assign req_full    = q_full;
   assign accept      = req_push && !q_full;
   // A count of three cannot arise; it is read as two.
   assign two_pending = cnt_ff[1];
   assign emit        = two_pending || req_final_byte;

   always_comb begin
      if (cnt_ff == 2'd0) begin
         b0 = req_data_byte;
         b1 = 8'h00;
         b2 = 8'h00;
         pad = 2'd2;
      end else if (!two_pending) begin
         b0 = pending_ff[15:8];
         b1 = req_data_byte;
         b2 = 8'h00;
         pad = 2'd1;
      end else begin
         b0 = pending_ff[15:8];
         b1 = pending_ff[7:0];
         b2 = req_data_byte;
         pad = 2'd0;
      end
   end

   assign line_sum   = line_ff + LINE_STEP;
   assign line_limit = {9'({1'b0, cfg_ff} + 9'd1), 2'b00};
   assign wrap       = !req_final_byte && (line_sum >= line_limit);

   assign q_push         = accept && emit;
   assign q_desc.sixes[0] = b0[7:2];
   assign q_desc.sixes[1] = {b0[1:0], b1[7:4]};
   assign q_desc.sixes[2] = {b1[3:0], b2[7:6]};
   assign q_desc.sixes[3] = b2[5:0];
   assign q_desc.pad      = pad;
   assign q_desc.wrap     = wrap;

   always_comb begin
      pending_in = pending_ff;
      cnt_in     = cnt_ff;
      line_in    = line_ff;
      if (accept) begin
         if (emit) begin
            pending_in = 16'h0000;
            cnt_in     = 2'd0;
            if (req_final_byte || wrap) begin
               line_in = 11'd0;
            end else begin
               line_in = line_sum;
            end
         end else begin
            if (cnt_ff == 2'd0) begin
               pending_in = {req_data_byte, 8'h00};
            end else begin
               pending_in = {pending_ff[15:8], req_data_byte};
            end
            cnt_in = cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= GROUPS_RESET;
         pending_ff <= 16'h0000;
         cnt_ff     <= 2'd0;
         line_ff    <= 11'd0;
      end else begin
         if (csr_write_enable) begin
            cfg_ff <= csr_write_data;
         end
         pending_ff <= pending_in;
         cnt_ff     <= cnt_in;
         line_ff    <= line_in;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("pending count reached three");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_final_byte) |=> (cnt_ff == 2'd0 && line_ff == 11'd0))
      else $error("final byte did not clear the group and line state");

endmodule

`default_nettype wire

### rtl/core/b64le_queue.sv
// Small register queue of group descriptors between the front and back ends.
`default_nettype none

module b64le_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire b64le_pkg::desc_type push_desc,
   output logic                     full,
   input  wire logic                pop,
   output b64le_pkg::desc_type      pop_desc,
   output logic                     empty
);
   import b64le_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_desc = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone push");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with the count");

endmodule

`default_nettype wire

### rtl/core/b64le_back.sv
// Back end: expands each group descriptor into its characters, with CR LF after a full line.
`default_nettype none

module b64le_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire b64le_pkg::desc_type q_desc,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [7:0]               rsp_out_char,
   output logic                     rsp_run_end
);
   import b64le_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff;
   logic [7:0] char_ff, char_in;
   logic       end_ff, end_in;

   logic       advance;
   logic [2:0] last_idx;
   logic       at_last;

   assign last_idx = q_desc.wrap ? LAST_WRAPPED : LAST_PLAIN;
   assign at_last  = (idx_ff == last_idx);
   // The output register refills if a group is queued and it is free or taken this cycle.
   assign advance  = !q_empty && (!valid_ff || rsp_pop);
   assign q_pop    = advance && at_last;

   always_comb begin
      if (idx_ff[2]) begin
         char_in = (idx_ff == IDX_CR) ? CHAR_CR : CHAR_LF;
      end else if (({1'b0, idx_ff[1:0]} + {1'b0, q_desc.pad}) >= 3'd4) begin
         char_in = CHAR_PAD;
      end else begin
         char_in = b64_symbol(q_desc.sixes[idx_ff[1:0]]);
      end
      end_in = at_last;
      idx_in = at_last ? 3'd0 : idx_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            idx_ff   <= idx_in;
            valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         char_ff <= char_in;
         end_ff  <= end_in;
      end
   end

   assign rsp_empty    = !valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_run_end  = end_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_WRAPPED)
      else $error("character index out of range");

   a_wrap_only: assert property (@(posedge clock) disable iff (reset)
      (idx_ff > LAST_PLAIN) |-> (!q_empty && q_desc.wrap))
      else $error("line break characters without a wrapped group");

endmodule

`default_nettype wire

### rtl/core/base64_line_wrapped_encoder.sv
// Top level of the streaming Base64 encoder with line wrapping.
//
//  channel  direction  handshake             payload
//  req      in         req_push / req_full   req_data_byte, req_final_byte
//  rsp      out        rsp_pop / rsp_empty   rsp_out_char, rsp_run_end
//  csr      in         csr_write_enable      csr_write_data
//
// The back end sends one character per cycle while the result side takes them, four per group
// or six when the group ends a line with CR LF.
// The front end takes a byte every cycle while the descriptor queue has room.
// Reset is synchronous; there is no clearing pass.
// A stalled result side holds the output register, and the queue absorbs QUEUE_DEPTH groups.
`default_nettype none

module base64_line_wrapped_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_final_byte,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_run_end,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data
);
   import b64le_pkg::*;

   logic     q_push, q_full, q_pop, q_empty;
   desc_type push_desc, head_desc;

   b64le_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_desc           (push_desc)
   );

   b64le_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_desc  (head_desc),
      .empty     (q_empty)
   );

   b64le_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_desc       (head_desc),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_char (rsp_out_char),
      .rsp_run_end  (rsp_run_end)
   );

endmodule

`default_nettype wire
